// ===== sv/cbc_pkg.sv =====
// cbc_pkg: shared types, widths and codes of the cartridge bank controller
// no dependencies; imported by every module of the block

package cbc_pkg;

    localparam int KIND_W      = 3;
    localparam int TOTAL_W     = 10;
    localparam int ROM_BYTES_W = 24;
    localparam int RAM_BYTES_W = 18;
    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int TARGET_W    = 2;
    localparam int OFFSET_W    = 23;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int WIN_ADDR_W  = 15;
    localparam int ROM_PAGE_W  = 14;
    localparam int RAM_PAGE_W  = 13;
    localparam int RAM_OFF_W   = 17;
    localparam int BANK_W      = 9;
    localparam int DIV_STEP    = 3;
    localparam int DIV_CYCLES  = BANK_W / DIV_STEP;

    localparam int DEFAULT_MAX_ROM_BANKS   = 512;
    localparam int DEFAULT_CLOCK_REG_COUNT = 5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [KIND_W-1:0] KIND_NONE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MBC1 = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MBC3 = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MBC5 = 3'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_KIND       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK_TOTAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_BYTES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BYTES  = 2'd3;

    localparam logic [TOTAL_W-1:0]     BANK_TOTAL_RST = 10'd2;
    localparam logic [ROM_BYTES_W-1:0] ROM_BYTES_RST  = 24'd32768;
    localparam logic [RAM_BYTES_W-1:0] RAM_BYTES_RST  = 18'd0;

    localparam logic [TARGET_W-1:0] TGT_NONE  = 2'd0;
    localparam logic [TARGET_W-1:0] TGT_ROM   = 2'd1;
    localparam logic [TARGET_W-1:0] TGT_RAM   = 2'd2;
    localparam logic [TARGET_W-1:0] TGT_CLOCK = 2'd3;

    localparam logic [1:0] CLS_ROM_READ = 2'd0;
    localparam logic [1:0] CLS_REG_WRITE = 2'd1;
    localparam logic [1:0] CLS_RAM      = 2'd2;
    localparam logic [1:0] CLS_OTHER    = 2'd3;

    localparam logic [1:0] REG_RAM_EN = 2'd0;
    localparam logic [1:0] REG_ROM_BANK = 2'd1;
    localparam logic [1:0] REG_HIGH   = 2'd2;
    localparam logic [1:0] REG_MODE   = 2'd3;

    localparam logic [DATA_W-1:0] OPEN_BUS       = 8'hFF;
    localparam logic [3:0]        RAM_EN_KEY     = 4'hA;
    localparam logic [DATA_W-1:0] CLOCK_SEL_BASE = 8'h08;
    localparam logic [DATA_W-1:0] CLOCK_SEL_LAST = 8'h0C;
    localparam logic [DATA_W-1:0] RAM_SEL_LAST   = 8'h03;

    typedef struct packed {
        logic [1:0]            cls;
        logic                  action;
        logic [WIN_ADDR_W-1:0] addr;
        logic [DATA_W-1:0]     data;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [TOTAL_W-1:0]     bank_total;
        logic [ROM_BYTES_W-1:0] rom_bytes;
        logic [RAM_BYTES_W-1:0] ram_bytes;
    } cfg_t;

endpackage

// ===== sv/cbc_req_if.sv =====
// cbc_req_if: bus access channel with valid/ready handshake
// depends on cbc_pkg for field widths

interface cbc_req_if;
    logic                             valid;
    logic                             ready;
    logic                             action;
    logic [cbc_pkg::ADDR_W-1:0]       bus_address;
    logic [cbc_pkg::DATA_W-1:0]       write_byte;

    modport source (output valid, output action, output bus_address, output write_byte,
                    input ready);
    modport sink   (input valid, input action, input bus_address, input write_byte,
                    output ready);
endinterface

// ===== sv/cbc_rsp_if.sv =====
// cbc_rsp_if: result channel with valid/ready handshake
// depends on cbc_pkg for field widths

interface cbc_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [cbc_pkg::TARGET_W-1:0]     target;
    logic [cbc_pkg::OFFSET_W-1:0]     mem_offset;
    logic                             ram_write_strobe;
    logic [cbc_pkg::DATA_W-1:0]       read_byte;

    modport source (output valid, output target, output mem_offset,
                    output ram_write_strobe, output read_byte, input ready);
    modport sink   (input valid, input target, input mem_offset,
                    input ram_write_strobe, input read_byte, output ready);
endinterface

// ===== sv/cbc_front.sv =====
// cbc_front: accepts bus accesses and sorts them into access classes
// depends on cbc_pkg and cbc_req_if; feeds cbc_queue

module cbc_front (
    cbc_req_if.sink          req,
    input  logic             full,
    output logic             push,
    output cbc_pkg::item_t   push_item
);
    import cbc_pkg::*;

    logic [1:0] cls;

    always_comb
    begin
        if (!req.bus_address[ADDR_W-1])
        begin
            cls = req.action ? CLS_REG_WRITE : CLS_ROM_READ;
        end
        else if (req.bus_address[ADDR_W-1:ADDR_W-3] == 3'b101)
        begin
            cls = CLS_RAM;
        end
        else
        begin
            cls = CLS_OTHER;
        end
    end

    assign req.ready        = !full;
    assign push             = req.valid && !full;
    assign push_item.cls    = cls;
    assign push_item.action = req.action;
    assign push_item.addr   = req.bus_address[WIN_ADDR_W-1:0];
    assign push_item.data   = req.write_byte;

endmodule

// ===== sv/cbc_queue.sv =====
// cbc_queue: short first-in first-out queue of classified transactions
// depends on cbc_pkg for the entry type and depth

module cbc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cbc_pkg::item_t   push_item,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output cbc_pkg::item_t   head
);
    import cbc_pkg::*;

    item_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/cbc_back.sv =====
// cbc_back: executes transactions: bank registers, bank wrap divider, results
// depends on cbc_pkg and cbc_rsp_if; drains cbc_queue

module cbc_back #(
    parameter int MAX_ROM_BANKS   = cbc_pkg::DEFAULT_MAX_ROM_BANKS,
    parameter int CLOCK_REG_COUNT = cbc_pkg::DEFAULT_CLOCK_REG_COUNT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cbc_pkg::cfg_t                cfg,
    input  logic                         kind_load,
    input  logic [cbc_pkg::KIND_W-1:0]   kind_value,
    input  logic                         head_valid,
    input  cbc_pkg::item_t               head,
    output logic                         pop,
    cbc_rsp_if.source                    rsp
);
    import cbc_pkg::*;

    localparam int CLK_IDX_W = (CLOCK_REG_COUNT > 1) ? $clog2(CLOCK_REG_COUNT) : 1;
    localparam logic [TOTAL_W-1:0] MAX_TOTAL = TOTAL_W'(MAX_ROM_BANKS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]          state_reg, state_next;
    item_t               item_reg, item_next;
    logic [BANK_W-1:0]   dividend_reg, dividend_next;
    logic [TOTAL_W-1:0]  rem_reg, rem_next;
    logic [1:0]          step_reg, step_next;

    logic                ram_enable_reg, ram_enable_next;
    logic [4:0]          mbc1_low_bank_reg, mbc1_low_bank_next;
    logic [1:0]          mbc1_high_bits_reg, mbc1_high_bits_next;
    logic                mbc1_mode_reg, mbc1_mode_next;
    logic [6:0]          mbc3_rom_bank_reg, mbc3_rom_bank_next;
    logic [7:0]          mbc3_select_reg, mbc3_select_next;
    logic [8:0]          mbc5_rom_bank_reg, mbc5_rom_bank_next;
    logic [3:0]          mbc5_ram_bank_reg, mbc5_ram_bank_next;
    logic [DATA_W-1:0]   clock_regs_reg [CLOCK_REG_COUNT];
    logic                clock_wr;
    logic [CLK_IDX_W-1:0] clock_idx;

    logic                out_valid_reg;
    logic [TARGET_W-1:0] target_reg, res_target;
    logic [OFFSET_W-1:0] offset_reg, res_offset;
    logic                strobe_reg, res_strobe;
    logic [DATA_W-1:0]   byte_reg, res_byte;

    logic [TOTAL_W-1:0]  total_eff;
    logic [BANK_W-1:0]   head_bank;
    logic                head_wrap;
    logic                do_div;
    logic [TOTAL_W-1:0]  div_rem;
    logic [BANK_W-1:0]   div_dvd;
    logic                emit_fire;
    logic [OFFSET_W-1:0] rom_off;
    logic [DATA_W-1:0]   refused;
    logic [DATA_W-1:0]   sel_off;
    logic [3:0]          ram_bank;
    logic                ram_ok;
    logic [RAM_OFF_W-1:0] ram_off;

    assign total_eff = (cfg.bank_total > MAX_TOTAL) ? MAX_TOTAL : cfg.bank_total;
    assign pop       = (state_reg == S_IDLE) && head_valid;
    assign emit_fire = (state_reg == S_EMIT) && (!out_valid_reg || rsp.ready);

    // bank number of a ROM read, taken from the queue head
    always_comb
    begin
        head_bank = {{(BANK_W-1){1'b0}}, head.addr[ROM_PAGE_W]};
        head_wrap = 1'b0;
        case (cfg.kind)
            KIND_MBC1:
            begin
                head_wrap = 1'b1;
                if (!head.addr[ROM_PAGE_W])
                begin
                    head_bank = mbc1_mode_reg ? {2'b00, mbc1_high_bits_reg, 5'b00000} : '0;
                end
                else
                begin
                    head_bank = {2'b00, (mbc1_mode_reg ? 2'b00 : mbc1_high_bits_reg),
                                 mbc1_low_bank_reg};
                    if (head_bank[4:0] == 5'd0)
                    begin
                        head_bank[0] = 1'b1;
                    end
                end
            end
            KIND_MBC3:
            begin
                if (head.addr[ROM_PAGE_W])
                begin
                    head_wrap = 1'b1;
                    head_bank = (mbc3_rom_bank_reg == '0) ? BANK_W'(1) :
                                {2'b00, mbc3_rom_bank_reg};
                end
            end
            KIND_MBC5:
            begin
                if (head.addr[ROM_PAGE_W])
                begin
                    head_wrap = 1'b1;
                    head_bank = mbc5_rom_bank_reg;
                end
            end
            default:
            begin
                head_wrap = 1'b0;
            end
        endcase
    end

    assign do_div = head_wrap && (total_eff != '0) && (head.cls == CLS_ROM_READ);

    // restoring remainder, three quotient bits per cycle
    always_comb
    begin
        div_rem = rem_reg;
        div_dvd = dividend_reg;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            div_rem = {div_rem[TOTAL_W-2:0], div_dvd[BANK_W-1]};
            div_dvd = {div_dvd[BANK_W-2:0], 1'b0};
            if (div_rem >= total_eff)
            begin
                div_rem = div_rem - total_eff;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    item_next     = head;
                    dividend_next = head_bank;
                    step_next     = '0;
                    if (do_div)
                    begin
                        rem_next   = '0;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        rem_next   = {1'b0, head_bank};
                        state_next = S_EMIT;
                    end
                end
            end
            S_DIV:
            begin
                rem_next      = div_rem;
                dividend_next = div_dvd;
                step_next     = step_reg + 1'b1;
                if (step_reg == 2'(DIV_CYCLES - 1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result and register updates of the transaction in item_reg
    always_comb
    begin
        ram_enable_next     = ram_enable_reg;
        mbc1_low_bank_next  = mbc1_low_bank_reg;
        mbc1_high_bits_next = mbc1_high_bits_reg;
        mbc1_mode_next      = mbc1_mode_reg;
        mbc3_rom_bank_next  = mbc3_rom_bank_reg;
        mbc3_select_next    = mbc3_select_reg;
        mbc5_rom_bank_next  = mbc5_rom_bank_reg;
        mbc5_ram_bank_next  = mbc5_ram_bank_reg;
        clock_wr   = 1'b0;
        clock_idx  = '0;
        res_target = TGT_NONE;
        res_offset = '0;
        res_strobe = 1'b0;
        res_byte   = '0;
        refused    = item_reg.action ? '0 : OPEN_BUS;
        rom_off    = {rem_reg[BANK_W-1:0], item_reg.addr[ROM_PAGE_W-1:0]};
        sel_off    = mbc3_select_reg - CLOCK_SEL_BASE;
        ram_bank   = '0;
        ram_ok     = 1'b1;
        ram_off    = '0;
        case (item_reg.cls)
            CLS_ROM_READ:
            begin
                if (cfg.rom_bytes == '0 || {1'b0, rom_off} >= cfg.rom_bytes)
                begin
                    res_byte = OPEN_BUS;
                end
                else
                begin
                    res_target = TGT_ROM;
                    res_offset = rom_off;
                end
            end
            CLS_REG_WRITE:
            begin
                case (cfg.kind)
                    KIND_MBC1:
                    begin
                        case (item_reg.addr[14:13])
                            REG_RAM_EN:   ram_enable_next = (item_reg.data[3:0] == RAM_EN_KEY);
                            REG_ROM_BANK: mbc1_low_bank_next = (item_reg.data[4:0] == 5'd0) ?
                                                               5'd1 : item_reg.data[4:0];
                            REG_HIGH:     mbc1_high_bits_next = item_reg.data[1:0];
                            default:      mbc1_mode_next = item_reg.data[0];
                        endcase
                    end
                    KIND_MBC3:
                    begin
                        case (item_reg.addr[14:13])
                            REG_RAM_EN:   ram_enable_next = (item_reg.data[3:0] == RAM_EN_KEY);
                            REG_ROM_BANK: mbc3_rom_bank_next = (item_reg.data[6:0] == 7'd0) ?
                                                               7'd1 : item_reg.data[6:0];
                            REG_HIGH:     mbc3_select_next = item_reg.data;
                            default:      mbc3_select_next = mbc3_select_reg;
                        endcase
                    end
                    KIND_MBC5:
                    begin
                        case (item_reg.addr[14:13])
                            REG_RAM_EN:   ram_enable_next = (item_reg.data[3:0] == RAM_EN_KEY);
                            REG_ROM_BANK:
                            begin
                                if (!item_reg.addr[12])
                                begin
                                    mbc5_rom_bank_next = {mbc5_rom_bank_reg[8], item_reg.data};
                                end
                                else
                                begin
                                    mbc5_rom_bank_next = {item_reg.data[0],
                                                          mbc5_rom_bank_reg[7:0]};
                                end
                            end
                            REG_HIGH:     mbc5_ram_bank_next = item_reg.data[3:0];
                            default:      mbc5_ram_bank_next = mbc5_ram_bank_reg;
                        endcase
                    end
                    default:
                    begin
                        ram_enable_next = ram_enable_reg;
                    end
                endcase
            end
            CLS_RAM:
            begin
                if (cfg.ram_bytes == '0 || !ram_enable_reg)
                begin
                    ram_ok   = 1'b0;
                    res_byte = refused;
                end
                else
                begin
                    case (cfg.kind)
                        KIND_MBC1: ram_bank = mbc1_mode_reg ? {2'b00, mbc1_high_bits_reg} : '0;
                        KIND_MBC3:
                        begin
                            if (mbc3_select_reg >= CLOCK_SEL_BASE &&
                                mbc3_select_reg <= CLOCK_SEL_LAST)
                            begin
                                ram_ok = 1'b0;
                                if (32'(sel_off) >= CLOCK_REG_COUNT)
                                begin
                                    res_byte = refused;
                                end
                                else
                                begin
                                    clock_idx  = CLK_IDX_W'(sel_off);
                                    clock_wr   = item_reg.action;
                                    res_target = TGT_CLOCK;
                                    res_byte   = item_reg.action ? item_reg.data :
                                                 clock_regs_reg[clock_idx];
                                end
                            end
                            else if (mbc3_select_reg > RAM_SEL_LAST)
                            begin
                                ram_ok   = 1'b0;
                                res_byte = refused;
                            end
                            else
                            begin
                                ram_bank = {2'b00, mbc3_select_reg[1:0]};
                            end
                        end
                        KIND_MBC5: ram_bank = mbc5_ram_bank_reg;
                        default:   ram_bank = '0;
                    endcase
                    ram_off = {ram_bank, item_reg.addr[RAM_PAGE_W-1:0]};
                    if (ram_ok)
                    begin
                        if ({1'b0, ram_off} >= cfg.ram_bytes)
                        begin
                            res_byte = refused;
                        end
                        else
                        begin
                            res_target = TGT_RAM;
                            res_offset = OFFSET_W'(ram_off);
                            res_strobe = item_reg.action;
                        end
                    end
                end
            end
            default:
            begin
                res_byte = refused;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            step_reg           <= '0;
            out_valid_reg      <= 1'b0;
            ram_enable_reg     <= 1'b1;
            mbc1_low_bank_reg  <= 5'd1;
            mbc1_high_bits_reg <= '0;
            mbc1_mode_reg      <= 1'b0;
            mbc3_rom_bank_reg  <= 7'd1;
            mbc3_select_reg    <= '0;
            mbc5_rom_bank_reg  <= 9'd1;
            mbc5_ram_bank_reg  <= '0;
            for (int i = 0; i < CLOCK_REG_COUNT; i++)
            begin
                clock_regs_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (kind_load)
            begin
                ram_enable_reg <= (kind_value == KIND_NONE);
            end
            else if (emit_fire)
            begin
                ram_enable_reg <= ram_enable_next;
            end
            if (emit_fire)
            begin
                mbc1_low_bank_reg  <= mbc1_low_bank_next;
                mbc1_high_bits_reg <= mbc1_high_bits_next;
                mbc1_mode_reg      <= mbc1_mode_next;
                mbc3_rom_bank_reg  <= mbc3_rom_bank_next;
                mbc3_select_reg    <= mbc3_select_next;
                mbc5_rom_bank_reg  <= mbc5_rom_bank_next;
                mbc5_ram_bank_reg  <= mbc5_ram_bank_next;
                if (clock_wr)
                begin
                    clock_regs_reg[clock_idx] <= item_reg.data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        if (emit_fire)
        begin
            target_reg <= res_target;
            offset_reg <= res_offset;
            strobe_reg <= res_strobe;
            byte_reg   <= res_byte;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.target           = target_reg;
    assign rsp.mem_offset       = offset_reg;
    assign rsp.ram_write_strobe = strobe_reg;
    assign rsp.read_byte        = byte_reg;

    a_div_needs_total: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> total_eff != '0)
        else $error("divider running with zero bank total");

    a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg != S_IDLE)
        else $error("popped transaction not taken up");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result shown without emit step");

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && $past(state_reg == S_DIV)) |-> rem_reg < total_eff)
        else $error("wrapped bank not below bank total");

endmodule

// ===== sv/cartridge_bank_controller_unit.sv =====
// cartridge_bank_controller_unit: top level of the cartridge bank controller
// depends on cbc_pkg, cbc_req_if, cbc_rsp_if, cbc_front, cbc_queue, cbc_back
//
//   port      kind         contents
//   req       sink         action, bus_address, write_byte
//   rsp       source       target, mem_offset, ram_write_strobe, read_byte
//   cfg_*     write port   cfg_write, cfg_index, cfg_data
//
// a transaction passes through the back end's idle and emit states; banked ROM reads
// first pass through the bank wrap divider state (3 remainder bits per cycle)
// rst_n empties the queue, clears the clock registers and resets bank registers and config to defaults
// a 2-entry queue keeps req ready, while it is not full, as the back end works or rsp stalls;
// a finished result sits in the output register until taken

module cartridge_bank_controller_unit #(
    parameter int MAX_ROM_BANKS   = cbc_pkg::DEFAULT_MAX_ROM_BANKS,
    parameter int CLOCK_REG_COUNT = cbc_pkg::DEFAULT_CLOCK_REG_COUNT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    cbc_req_if.sink                          req,
    cbc_rsp_if.source                        rsp,
    input  logic                             cfg_write,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cbc_pkg::*;

    cfg_t  cfg_reg;
    logic  kind_load;
    logic  push;
    item_t push_item;
    logic  full;
    logic  pop;
    logic  head_valid;
    item_t head;

    assign kind_load = cfg_write && (cfg_index == CFG_KIND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kind       <= KIND_NONE;
            cfg_reg.bank_total <= BANK_TOTAL_RST;
            cfg_reg.rom_bytes  <= ROM_BYTES_RST;
            cfg_reg.ram_bytes  <= RAM_BYTES_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_KIND:       cfg_reg.kind       <= cfg_data[KIND_W-1:0];
                CFG_BANK_TOTAL: cfg_reg.bank_total <= cfg_data[TOTAL_W-1:0];
                CFG_ROM_BYTES:  cfg_reg.rom_bytes  <= cfg_data[ROM_BYTES_W-1:0];
                CFG_RAM_BYTES:  cfg_reg.ram_bytes  <= cfg_data[RAM_BYTES_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    cbc_front u_front (
        .req       (req),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    cbc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    cbc_back #(
        .MAX_ROM_BANKS   (MAX_ROM_BANKS),
        .CLOCK_REG_COUNT (CLOCK_REG_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .kind_load  (kind_load),
        .kind_value (cfg_data[KIND_W-1:0]),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule
